[hdl/dsi_dcs_write_packer_defines.svh]
// Assertion macros shared by the DCS write packer modules.
`ifndef DSI_DCS_WRITE_PACKER_DEFINES_SVH
`define DSI_DCS_WRITE_PACKER_DEFINES_SVH

// Same-cycle implication, checked on clk, disabled while rst_n is low.
`define DSIDCSWP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcs write packer assertion failed");

// Next-cycle implication, checked on clk, disabled while rst_n is low.
`define DSIDCSWP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcs write packer assertion failed");

`endif

[hdl/dsidcswp_pkg.sv]
// Types and constants of the DCS write packer.
`timescale 1ns / 1ps

package dsidcswp_pkg;

    localparam logic [5:0] DT_SHORT       = 6'h05;
    localparam logic [5:0] DT_SHORT_PARAM = 6'h15;
    localparam logic [5:0] DT_LONG        = 6'h39;

    localparam logic RK_WORD = 1'b0;
    localparam logic RK_SEND = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic        word_valid;
        logic [4:0]  word_addr;
        logic [63:0] word_data;
        logic        send_valid;
        logic [5:0]  data_type;
        logic [7:0]  arg0;
        logic [7:0]  arg1;
        logic        overflow;
    } job_t;

    typedef struct packed {
        logic head_valid;
        logic full;
    } q_status_t;

endpackage

[hdl/dsidcswp_front.sv]
// Front end: accepts command bytes, packs groups and classifies each transaction into a job.
`timescale 1ns / 1ps

module dsidcswp_front #(
    parameter int MAX_PAYLOAD = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               is_last,
    output logic               push,
    output dsidcswp_pkg::job_t push_job
);

    localparam logic [7:0] LIMIT = 8'(MAX_PAYLOAD + 1);

    logic [63:0] group_reg, group_next;
    logic [7:0]  total_reg, total_next;
    logic [4:0]  index_reg, index_next;
    logic        dropped_reg, dropped_next;

    logic        accept;
    logic        take;
    logic [2:0]  pos;
    logic [63:0] grp_a;
    logic [7:0]  total_a;
    logic        drop_a;
    logic        full_word;
    logic        long_cmd;

    always_comb
    begin
        accept  = in_valid && in_ready;
        take    = total_reg < LIMIT;
        pos     = total_reg[2:0];
        grp_a   = group_reg;
        for (int i = 0; i < 8; i++)
        begin
            if (take && (pos == 3'(i)))
            begin
                grp_a[i*8 +: 8] = data_byte;
            end
        end
        total_a   = take ? total_reg + 8'd1 : total_reg;
        drop_a    = dropped_reg | ~take;
        full_word = take && (total_a[2:0] == 3'd0);
        long_cmd  = total_a > 8'd2;

        push_job            = '0;
        push_job.word_valid = full_word || (is_last && long_cmd && (total_a[2:0] != 3'd0));
        push_job.word_addr  = index_reg;
        push_job.word_data  = grp_a;
        push_job.send_valid = is_last;
        push_job.overflow   = drop_a;
        if (total_a <= 8'd1)
        begin
            push_job.data_type = dsidcswp_pkg::DT_SHORT;
            push_job.arg0      = grp_a[7:0];
        end
        else if (total_a == 8'd2)
        begin
            push_job.data_type = dsidcswp_pkg::DT_SHORT_PARAM;
            push_job.arg0      = grp_a[7:0];
            push_job.arg1      = grp_a[15:8];
        end
        else
        begin
            push_job.data_type = dsidcswp_pkg::DT_LONG;
            push_job.arg0      = total_a;
        end

        push = accept && (push_job.word_valid || is_last);

        group_next   = group_reg;
        total_next   = total_reg;
        index_next   = index_reg;
        dropped_next = dropped_reg;
        if (accept)
        begin
            if (is_last)
            begin
                group_next   = '0;
                total_next   = '0;
                index_next   = '0;
                dropped_next = 1'b0;
            end
            else
            begin
                group_next   = full_word ? 64'd0 : grp_a;
                total_next   = total_a;
                index_next   = full_word ? index_reg + 5'd1 : index_reg;
                dropped_next = drop_a;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg   <= '0;
            total_reg   <= '0;
            index_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            group_reg   <= group_next;
            total_reg   <= total_next;
            index_reg   <= index_next;
            dropped_reg <= dropped_next;
        end
    end

endmodule

[hdl/dsidcswp_queue.sv]
// Job queue between the front end and the result sequencer.
`timescale 1ns / 1ps
`include "dsi_dcs_write_packer_defines.svh"

module dsidcswp_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  dsidcswp_pkg::job_t        push_job,
    input  logic                      pop,
    output dsidcswp_pkg::q_status_t   status,
    output dsidcswp_pkg::job_t        head_job
);

    dsidcswp_pkg::job_t entries [dsidcswp_pkg::QUEUE_DEPTH];

    logic [dsidcswp_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [dsidcswp_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dsidcswp_pkg::QCNT_W-1:0] count_reg, count_next;

    function automatic logic QPTR_W_GAP(
        input logic [dsidcswp_pkg::QPTR_W-1:0] wp,
        input logic [dsidcswp_pkg::QPTR_W-1:0] rp,
        input logic [dsidcswp_pkg::QCNT_W-1:0] cnt
    );
        logic [dsidcswp_pkg::QPTR_W-1:0] gap;
        gap = wp - rp;
        return gap == cnt[dsidcswp_pkg::QPTR_W-1:0];
    endfunction

    always_comb
    begin
        status.head_valid = count_reg != '0;
        status.full       = count_reg == dsidcswp_pkg::QCNT_W'(dsidcswp_pkg::QUEUE_DEPTH);
        head_job          = entries[rd_ptr_reg];
        wr_ptr_next       = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next       = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next        = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `DSIDCSWP_ASSERT_NOW(a_no_pop_empty, pop, status.head_valid)
    `DSIDCSWP_ASSERT_NOW(a_no_push_full, push, !status.full)
    `DSIDCSWP_ASSERT_NOW(a_ptr_gap, 1'b1, (QPTR_W_GAP(wr_ptr_reg, rd_ptr_reg, count_reg)))

endmodule

[hdl/dsidcswp_back.sv]
// Result sequencer: drains jobs into word writes and send commands through an output register.
`timescale 1ns / 1ps
`include "dsi_dcs_write_packer_defines.svh"

module dsidcswp_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dsidcswp_pkg::q_status_t   status,
    input  dsidcswp_pkg::job_t        head_job,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      result_kind,
    output logic [4:0]                mem_addr,
    output logic [31:0]               word_low,
    output logic [31:0]               word_high,
    output logic [5:0]                data_type,
    output logic [7:0]                send_arg0,
    output logic [7:0]                send_arg1,
    output logic                      overflow,
    output logic                      run_last
);

    logic        out_valid_reg, out_valid_next;
    logic        phase_reg, phase_next;
    logic        kind_reg, kind_next;
    logic [4:0]  addr_reg, addr_next;
    logic [63:0] data_reg, data_next;
    logic [5:0]  dtype_reg, dtype_next;
    logic [7:0]  arg0_reg, arg0_next;
    logic [7:0]  arg1_reg, arg1_next;
    logic        ovf_reg, ovf_next;
    logic        last_reg, last_next;
    logic        load;

    always_comb
    begin
        load           = !out_valid_reg || out_ready;
        pop            = 1'b0;
        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        addr_next      = addr_reg;
        data_next      = data_reg;
        dtype_next     = dtype_reg;
        arg0_next      = arg0_reg;
        arg1_next      = arg1_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        if (load)
        begin
            out_valid_next = status.head_valid;
            if (status.head_valid)
            begin
                if (head_job.word_valid && !phase_reg)
                begin
                    kind_next  = dsidcswp_pkg::RK_WORD;
                    addr_next  = head_job.word_addr;
                    data_next  = head_job.word_data;
                    dtype_next = '0;
                    arg0_next  = '0;
                    arg1_next  = '0;
                    ovf_next   = 1'b0;
                    last_next  = !head_job.send_valid;
                    phase_next = head_job.send_valid;
                    pop        = !head_job.send_valid;
                end
                else
                begin
                    kind_next  = dsidcswp_pkg::RK_SEND;
                    addr_next  = '0;
                    data_next  = '0;
                    dtype_next = head_job.data_type;
                    arg0_next  = head_job.arg0;
                    arg1_next  = head_job.arg1;
                    ovf_next   = head_job.overflow;
                    last_next  = 1'b1;
                    phase_next = 1'b0;
                    pop        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        addr_reg  <= addr_next;
        data_reg  <= data_next;
        dtype_reg <= dtype_next;
        arg0_reg  <= arg0_next;
        arg1_reg  <= arg1_next;
        ovf_reg   <= ovf_next;
        last_reg  <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign mem_addr    = addr_reg;
    assign word_low    = data_reg[31:0];
    assign word_high   = data_reg[63:32];
    assign data_type   = dtype_reg;
    assign send_arg0   = arg0_reg;
    assign send_arg1   = arg1_reg;
    assign overflow    = ovf_reg;
    assign run_last    = last_reg;

    `DSIDCSWP_ASSERT_NOW(a_phase_has_job, phase_reg,
        status.head_valid && head_job.word_valid && head_job.send_valid)
    `DSIDCSWP_ASSERT_NOW(a_send_is_last, out_valid_reg && (kind_reg == dsidcswp_pkg::RK_SEND), last_reg)
    `DSIDCSWP_ASSERT_NEXT(a_word_then_send, pop && phase_reg,
        out_valid_reg && (kind_reg == dsidcswp_pkg::RK_SEND))

endmodule

[hdl/dsi_dcs_write_packer.sv]
// Top level of the DCS write packer.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid/in_ready) carries one DCS command byte per
// transaction: the command byte first, then its parameters, is_last set on the
// final byte. The output channel (out_valid/out_ready) carries one result per
// transaction: a command memory word write (result_kind 0) or a send packet
// command (result_kind 1), with run_last set on the final result of a byte.
// Throughput: one byte per cycle while in_ready is high. A byte that yields results
// shows its first result from the output register after its job has passed through the
// queue; a second result (partial word then long write) follows once the first is taken.
// The front end and the output sequencer are joined by a four-entry job queue;
// in_ready drops only when that queue is full, so a stalled receiver backs up
// the input after four pending jobs plus the result held at the output.
// Bytes past MAX_PAYLOAD+1 in one command are dropped and flagged in the send.
// Reset empties the queue, drops any held result and clears the packing state;
// no clearing pass follows, the block accepts bytes as soon as reset is released.
module dsi_dcs_write_packer #(
    parameter int MAX_PAYLOAD = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [4:0]  mem_addr,
    output logic [31:0] word_low,
    output logic [31:0] word_high,
    output logic [5:0]  data_type,
    output logic [7:0]  send_arg0,
    output logic [7:0]  send_arg1,
    output logic        overflow,
    output logic        run_last
);

    logic                      push;
    logic                      pop;
    dsidcswp_pkg::job_t        push_job;
    dsidcswp_pkg::job_t        head_job;
    dsidcswp_pkg::q_status_t   status;

    assign in_ready = !status.full;

    dsidcswp_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .is_last   (is_last),
        .push      (push),
        .push_job  (push_job)
    );

    dsidcswp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .status   (status),
        .head_job (head_job)
    );

    dsidcswp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .status      (status),
        .head_job    (head_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .mem_addr    (mem_addr),
        .word_low    (word_low),
        .word_high   (word_high),
        .data_type   (data_type),
        .send_arg0   (send_arg0),
        .send_arg1   (send_arg1),
        .overflow    (overflow),
        .run_last    (run_last)
    );

endmodule

[tb/dsi_dcs_write_packer_checker.sv]
// Checker for the DCS write packer: predicts results per accepted byte and compares.
`timescale 1ns / 1ps

module dsi_dcs_write_packer_checker #(
    parameter int MAX_PAYLOAD = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        is_last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        result_kind,
    input  logic [4:0]  mem_addr,
    input  logic [31:0] word_low,
    input  logic [31:0] word_high,
    input  logic [5:0]  data_type,
    input  logic [7:0]  send_arg0,
    input  logic [7:0]  send_arg1,
    input  logic        overflow,
    input  logic        run_last,
    output int          fails,
    output int          pending
);

    typedef struct packed {
        logic        kind;
        logic [4:0]  addr;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [5:0]  dt;
        logic [7:0]  arg0;
        logic [7:0]  arg1;
        logic        ovf;
        logic        last;
    } dcs_result_t;

    dcs_result_t packed_results_q[$];

    logic [63:0] group_acc   = '0;
    logic [7:0]  byte_count  = '0;
    logic [4:0]  next_word   = '0;
    logic        byte_dropped = 1'b0;
    int          mismatch_count = 0;

    function automatic dcs_result_t make_word(input logic [4:0] a, input logic [63:0] g);
        dcs_result_t r;
        r = '{kind: dsidcswp_pkg::RK_WORD, addr: a, lo: g[31:0], hi: g[63:32], dt: 6'd0,
              arg0: 8'd0, arg1: 8'd0, ovf: 1'b0, last: 1'b0};
        return r;
    endfunction

    function automatic dcs_result_t make_send(input logic [5:0] dt, input logic [7:0] a0,
                                              input logic [7:0] a1, input logic ovf);
        dcs_result_t r;
        r = '{kind: dsidcswp_pkg::RK_SEND, addr: 5'd0, lo: 32'd0, hi: 32'd0, dt: dt,
              arg0: a0, arg1: a1, ovf: ovf, last: 1'b0};
        return r;
    endfunction

    function automatic string fmt_result(input dcs_result_t r);
        return $sformatf("kind=%0d addr=%0d lo=%h hi=%h dt=%h a0=%h a1=%h ovf=%0d last=%0d",
                         r.kind, r.addr, r.lo, r.hi, r.dt, r.arg0, r.arg1, r.ovf, r.last);
    endfunction

    task automatic pack_byte(input logic [7:0] b, input logic fin);
        dcs_result_t res [2];
        int          n;
        logic [2:0]  pos;
        n = 0;
        if (int'(byte_count) < MAX_PAYLOAD + 1)
        begin
            pos        = byte_count[2:0];
            group_acc  = group_acc | (64'(b) << (8 * pos));
            byte_count = byte_count + 8'd1;
            if (byte_count[2:0] == 3'd0)
            begin
                res[n]    = make_word(next_word, group_acc);
                n++;
                group_acc = '0;
                next_word = next_word + 5'd1;
            end
        end
        else
        begin
            byte_dropped = 1'b1;
        end
        if (fin)
        begin
            if (byte_count <= 8'd1)
            begin
                res[n] = make_send(dsidcswp_pkg::DT_SHORT, group_acc[7:0], 8'd0, byte_dropped);
                n++;
            end
            else if (byte_count == 8'd2)
            begin
                res[n] = make_send(dsidcswp_pkg::DT_SHORT_PARAM, group_acc[7:0],
                                   group_acc[15:8], byte_dropped);
                n++;
            end
            else
            begin
                if (byte_count[2:0] != 3'd0)
                begin
                    res[n] = make_word(next_word, group_acc);
                    n++;
                end
                res[n] = make_send(dsidcswp_pkg::DT_LONG, byte_count, 8'd0, byte_dropped);
                n++;
            end
            group_acc    = '0;
            byte_count   = '0;
            next_word    = '0;
            byte_dropped = 1'b0;
        end
        if (n > 0)
        begin
            res[n - 1].last = 1'b1;
            for (int i = 0; i < n; i++)
                packed_results_q.push_back(res[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        dcs_result_t got;
        dcs_result_t want;
        if (!rst_n)
        begin
            packed_results_q.delete();
            group_acc    = '0;
            byte_count   = '0;
            next_word    = '0;
            byte_dropped = 1'b0;
            pending     <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{kind: result_kind, addr: mem_addr, lo: word_low, hi: word_high,
                        dt: data_type, arg0: send_arg0, arg1: send_arg1, ovf: overflow,
                        last: run_last};
                if (packed_results_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: %s", fmt_result(got));
                end
                else
                begin
                    want = packed_results_q.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("mismatch expected: %s", fmt_result(want));
                            $display("mismatch actual:   %s", fmt_result(got));
                        end
                    end
                end
            end
            if (in_valid && in_ready)
                pack_byte(data_byte, is_last);
            pending <= packed_results_q.size();
        end
        fails <= mismatch_count;
    end

endmodule

[tb/tb_dsi_dcs_write_packer.sv]
// Testbench top for the DCS write packer: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module tb_dsi_dcs_write_packer;

    localparam int MAX_PAYLOAD = 128;
    localparam int ITEM_TARGET = 500;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        is_last   = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        result_kind;
    logic [4:0]  mem_addr;
    logic [31:0] word_low;
    logic [31:0] word_high;
    logic [5:0]  data_type;
    logic [7:0]  send_arg0;
    logic [7:0]  send_arg1;
    logic        overflow;
    logic        run_last;

    int fails;
    int pending;
    int bytes_sent = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;

    always #10 clk = ~clk;

    dsi_dcs_write_packer #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_kind(result_kind),
        .mem_addr   (mem_addr),
        .word_low   (word_low),
        .word_high  (word_high),
        .data_type  (data_type),
        .send_arg0  (send_arg0),
        .send_arg1  (send_arg1),
        .overflow   (overflow),
        .run_last   (run_last)
    );

    dsi_dcs_write_packer_checker #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_kind(result_kind),
        .mem_addr   (mem_addr),
        .word_low   (word_low),
        .word_high  (word_high),
        .data_type  (data_type),
        .send_arg0  (send_arg0),
        .send_arg1  (send_arg1),
        .overflow   (overflow),
        .run_last   (run_last),
        .fails      (fails),
        .pending    (pending)
    );

    // Receiver stall pattern: phases of always ready, coin flip, mostly stalled, toggling.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 80);
        end
        stall_left--;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= $urandom_range(0, 1);
            2:       out_ready <= ($urandom_range(0, 4) == 0);
            default: out_ready <= stall_left[1];
        endcase
    end

    // Send one byte as a transaction; open a new burst after a random gap when one runs out.
    task automatic put_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                      : $urandom_range(1, 40);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        is_last   <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_cmd(input int len);
        for (int i = 0; i < len; i++)
            put_byte(8'($urandom_range(0, 255)), i == len - 1);
    endtask

    initial
    begin
        int len;
        int cmd_idx;
        int guard;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        put_byte(8'h00, 1'b1);
        put_byte(8'hFF, 1'b1);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b1);
        put_byte(8'hA5, 1'b0);
        put_byte(8'h5A, 1'b0);
        put_byte(8'hFF, 1'b1);
        send_cmd(8);
        send_cmd(9);

        cmd_idx = 0;
        while (bytes_sent < ITEM_TARGET)
        begin
            if (cmd_idx % 10 == 5)
                len = $urandom_range(125, 140);
            else if ($urandom_range(0, 2) == 0)
                len = $urandom_range(1, 2);
            else
                len = $urandom_range(3, 24);
            send_cmd(len);
            cmd_idx++;
        end
        in_valid <= 1'b0;
        is_last  <= 1'b0;
        @(posedge clk);

        guard = 0;
        while (pending != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);

        if (fails == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/dsidcswp_pkg.sv
hdl/dsidcswp_front.sv
hdl/dsidcswp_queue.sv
hdl/dsidcswp_back.sv
hdl/dsi_dcs_write_packer.sv
tb/dsi_dcs_write_packer_checker.sv
tb/tb_dsi_dcs_write_packer.sv
